FILE: rtl/height_grid_box_smoothing_macros.svh
// Assertion helpers for the grid smoother.
`ifndef HEIGHT_GRID_BOX_SMOOTHING_MACROS_SVH
`define HEIGHT_GRID_BOX_SMOOTHING_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define HGBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define HGBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hgbs_pkg.sv
package hgbs_pkg;
  localparam int MAX_ROWS   = 128;
  localparam int MAX_COLS   = 128;
  localparam int MAX_RADIUS = 7;
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int CELLS  = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int H_W    = 20;
  localparam int SUM_W  = 32;
  localparam logic signed [H_W-1:0] ONE_Q16 = 20'sd65536;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_RADIUS = 2'd2,
    REG_PASSES = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HREAD,
    S_HWAIT,
    S_HWRITE,
    S_VREAD,
    S_VWAIT,
    S_VWRITE,
    S_DIV,
    S_CREAD,
    S_CWAIT,
    S_CWRITE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [SUM_W-1:0] num;
    logic [7:0] den;
  } div_req_t;

  // reciprocal-free area table: (2r+1)^2
  function automatic logic [7:0] area_of(input logic [2:0] r);
    logic [7:0] s;
    s = {4'd0, r, 1'b1};
    return 8'((s * s));
  endfunction
endpackage

FILE: rtl/hgbs_ram.sv
module hgbs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/hgbs_div.sv
module hgbs_div
  import hgbs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  div_req_t                req,
  output logic                    busy,
  output logic signed [H_W-1:0]   quo
);
  logic [SUM_W-1:0] rem_r, rem_nxt, q_r, q_nxt;
  logic [7:0]       den_r;
  logic             neg_r;
  logic [5:0]       cnt_r;
  logic [SUM_W:0]   trial;
  logic [SUM_W-1:0] qs;

  // restoring division on magnitudes, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, q_r[SUM_W-1]} - {{(SUM_W-7){1'b0}}, den_r};
    rem_nxt = trial[SUM_W] ? {rem_r[SUM_W-2:0], q_r[SUM_W-1]} : trial[SUM_W-1:0];
    q_nxt   = {q_r[SUM_W-2:0], ~trial[SUM_W]};
    qs      = neg_r ? (~q_r + 1'b1) : q_r;
  end

  assign busy = (cnt_r != 6'd0);
  assign quo  = qs[H_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (req.start) begin
      cnt_r <= 6'(SUM_W);
      rem_r <= '0;
      q_r   <= req.num[SUM_W-1] ? SUM_W'(-req.num) : req.num;
      neg_r <= req.num[SUM_W-1];
      den_r <= req.den;
    end else if (busy) begin
      cnt_r <= cnt_r - 6'd1;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end
endmodule

FILE: rtl/height_grid_box_smoothing.sv
// Channel | Direction | Ports
// in      | input     | in_valid in_ready in_cmd in_row in_col in_height_in
// out     | output    | out_valid out_ready out_height_out out_done_kind
// cfg     | input     | cfg_we cfg_index cfg_wdata
// Load, read and unused commands are accepted, then give one result;
// one item is in flight at a time.
// A run's speed is limited by the single read port of the grid memory and the serial divider.
// Reset is synchronous; memory contents are not cleared.
// A stalled result holds in the output register; input waits until it leaves.
module height_grid_box_smoothing
  import hgbs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic [6:0]            in_row,
  input  logic [6:0]            in_col,
  input  logic signed [19:0]    in_height_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [19:0]    out_height_out,
  output logic [1:0]            out_done_kind,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_wdata
);
`include "height_grid_box_smoothing_macros.svh"

  logic [7:0] rows_r, cols_r, passes_r;
  logic [2:0] rad_r;

  state_t state_r, state_nxt;
  logic [1:0] cmd_r;
  logic [ROW_W-1:0] i_r;
  logic [COL_W-1:0] j_r;
  logic [7:0] k_r, p_r;
  logic signed [SUM_W-1:0] acc_r;
  logic signed [H_W-1:0] res_r;
  logic [8:0] erows, ecols;
  logic [8:0] lo, hi, cnt_hi;

  // grid memory and line-sum scratch
  logic g_we, s_we;
  logic [ADDR_W-1:0] g_wa, g_ra, s_wa, s_ra;
  logic [H_W-1:0] g_wd, g_rd;
  logic [SUM_W-1:0] s_wd, s_rd;
  div_req_t dreq;
  logic d_busy;
  logic signed [H_W-1:0] d_quo;

  hgbs_ram #(.WIDTH(H_W), .DEPTH(CELLS)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd));
  hgbs_ram #(.WIDTH(SUM_W), .DEPTH(CELLS)) u_line (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  hgbs_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(d_busy), .quo(d_quo));

  always_comb begin
    erows = (rows_r > 8'(MAX_ROWS)) ? 9'(MAX_ROWS) : {1'b0, rows_r};
    ecols = (cols_r > 8'(MAX_COLS)) ? 9'(MAX_COLS) : {1'b0, cols_r};
  end

  // window bounds: along columns in H phase, along rows in V phase
  logic hphase;
  logic [8:0] ctr, lim;
  always_comb begin
    hphase = (state_r == S_HREAD) || (state_r == S_HWAIT) || (state_r == S_HWRITE);
    ctr = hphase ? {2'b0, j_r} : {2'b0, i_r};
    lim = hphase ? ecols : erows;
    lo  = (ctr >= {6'd0, rad_r}) ? ctr - {6'd0, rad_r} : 9'd0;
    hi  = (ctr + {6'd0, rad_r} < lim - 9'd1) ? ctr + {6'd0, rad_r} : lim - 9'd1;
    cnt_hi = hi;
  end

  logic [8:0] kpos;
  assign kpos = lo + {1'b0, k_r};
  logic last_k, last_cell, last_pass;
  assign last_k    = (kpos == cnt_hi);
  assign last_cell = ({2'b0, j_r} == ecols - 9'd1) && ({2'b0, i_r} == erows - 9'd1);
  assign last_pass = (p_r + 8'd1 >= passes_r);

  logic in_grid, acc_in;
  assign in_grid = ({2'b0, in_row} < erows) && ({2'b0, in_col} < ecols);
  assign acc_in = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc_in) begin
        if (in_cmd == CMD_RUN && erows != 0 && ecols != 0)
          state_nxt = (passes_r == 8'd0) ? S_CREAD : S_HREAD;
        else state_nxt = S_OUT;
      end
      S_HREAD:  state_nxt = last_k ? S_HWAIT : S_HREAD;
      S_HWAIT:  state_nxt = S_HWRITE;
      S_HWRITE: state_nxt = last_cell ? S_VREAD : S_HREAD;
      S_VREAD:  state_nxt = last_k ? S_VWAIT : S_VREAD;
      S_VWAIT:  state_nxt = S_DIV;
      S_DIV:    state_nxt = d_busy ? S_DIV : S_VWRITE;
      S_VWRITE: state_nxt = last_cell ? (last_pass ? S_CREAD : S_HREAD) : S_VREAD;
      S_CREAD:  state_nxt = S_CWAIT;
      S_CWAIT:  state_nxt = S_CWRITE;
      S_CWRITE: state_nxt = last_cell ? S_OUT : S_CREAD;
      S_OUT:    state_nxt = (out_valid && out_ready) ? S_IDLE : S_OUT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  logic [ADDR_W-1:0] here, kaddr;
  assign here  = {i_r, j_r};
  assign kaddr = hphase ? {i_r, kpos[COL_W-1:0]} : {kpos[ROW_W-1:0], j_r};

  logic signed [H_W-1:0] clamped;
  always_comb begin
    if ($signed(g_rd) < 0) clamped = '0;
    else if ($signed(g_rd) > ONE_Q16) clamped = ONE_Q16;
    else clamped = g_rd;
  end

  // memory and divider controls
  always_comb begin
    g_we = 1'b0; g_wa = here; g_wd = '0; g_ra = here;
    s_we = 1'b0; s_wa = here; s_wd = acc_r; s_ra = kaddr;
    dreq.start = 1'b0; dreq.num = acc_r; dreq.den = area_of(rad_r);
    unique case (state_r)
      S_IDLE: begin
        g_ra = {in_row, in_col};
        g_wa = {in_row, in_col};
        g_wd = in_height_in;
        g_we = acc_in && (in_cmd == CMD_LOAD) && in_grid;
      end
      S_HREAD: g_ra = kaddr;
      S_HWRITE: s_we = 1'b1;
      // the last line sum arrives this cycle; fold it in on the way to the divider
      S_VWAIT: begin dreq.start = 1'b1; dreq.num = acc_r + $signed(s_rd); end
      S_VWRITE: begin g_we = 1'b1; g_wd = d_quo; end
      S_CWRITE: begin g_we = 1'b1; g_wd = clamped; end
      default: ;
    endcase
  end

  // accumulator adds the word read in the previous cycle
  logic rd_h_r, rd_v_r;
  always_ff @(posedge clk) begin
    rd_h_r <= (state_r == S_HREAD);
    rd_v_r <= (state_r == S_VREAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rows_r   <= 8'd128;
      cols_r   <= 8'd128;
      rad_r    <= 3'd1;
      passes_r <= 8'd1;
      out_valid <= 1'b0;
      i_r <= '0; j_r <= '0; k_r <= '0; p_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ROWS:   rows_r   <= cfg_wdata;
          REG_COLS:   cols_r   <= cfg_wdata;
          REG_RADIUS: rad_r    <= cfg_wdata[2:0];
          REG_PASSES: passes_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_IDLE && acc_in) begin
        cmd_r <= in_cmd;
        i_r <= '0; j_r <= '0; k_r <= '0; p_r <= '0;
        acc_r <= '0;
      end
      if (rd_h_r) acc_r <= acc_r + SUM_W'(signed'(g_rd));
      if (rd_v_r) acc_r <= acc_r + s_rd;
      if (state_r == S_HREAD || state_r == S_VREAD)
        k_r <= last_k ? 8'd0 : k_r + 8'd1;
      // advance the cell scan after each write-back
      if (state_r == S_HWRITE || state_r == S_VWRITE || state_r == S_CWRITE) begin
        acc_r <= '0;
        if ({2'b0, j_r} == ecols - 9'd1) begin
          j_r <= '0;
          i_r <= last_cell ? '0 : i_r + 1'b1;
        end else j_r <= j_r + 1'b1;
        if (state_r == S_VWRITE && last_cell) p_r <= p_r + 8'd1;
      end
      // capture the result
      if (state_nxt == S_OUT && state_r != S_OUT) out_valid <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  logic rd_sel_r;
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && acc_in) rd_sel_r <= (in_cmd == CMD_READ) && in_grid;
  end
  always_comb res_r = rd_sel_r && cmd_r == CMD_READ ? g_rd : '0;
  // grid read data does not hold in S_OUT, since g_ra moves to 'here' there;
  // keep a copy for stalls
  logic signed [H_W-1:0] hold_r;
  logic first_out_r;
  always_ff @(posedge clk) begin
    first_out_r <= (state_r != S_OUT) && (state_nxt == S_OUT);
    if (first_out_r) hold_r <= res_r;
  end
  assign out_height_out = first_out_r ? res_r : hold_r;
  assign out_done_kind  = cmd_r;

  `HGBS_ASSERT_IMP(a_ready_idle, in_ready, !out_valid || state_r == S_IDLE,
    "ready outside idle")
  `HGBS_ASSERT_NXT(a_hold_out, out_valid && !out_ready, out_valid,
    "result dropped while stalled")
  `HGBS_ASSERT_IMP(a_no_write_out, state_r == S_OUT, !g_we,
    "grid written while result pending")
endmodule
